/* sv/tmcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// shared constants, op codes and the placement struct of the text console
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// default grid size
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// cursor widths wide enough for the largest grid (256 columns, 255 rows + past end)
	localparam int COL_W = 8;
	localparam int ROW_W = 8;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] SPACE_CHAR   = 8'd32;
	localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// where a command lands and what it leaves behind
	typedef struct packed {
		logic [1:0]       scroll_n;
		logic             wr_cell;
		logic             rd_ok;
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] nxt_col;
		logic [ROW_W-1:0] nxt_row;
	} place_t;

endpackage

/* sv/tmcw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_if
// valid/ready channels for console commands and console responses
// ----------------------------------------------------------------------------
interface tmcw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] ch;
	logic [6:0] col;
	logic [4:0] row;
	logic       use_position;

	modport source (output valid, op, ch, col, row, use_position, input ready);
	modport sink (input valid, op, ch, col, row, use_position, output ready);
endinterface

interface tmcw_rsp_if;
	logic       valid;
	logic       ready;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic       scrolled;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;

	modport source (output valid, cursor_col, cursor_row, scrolled, cell_char, cell_attr,
		input ready);
	modport sink (input valid, cursor_col, cursor_row, scrolled, cell_char, cell_attr,
		output ready);
endinterface

/* sv/tmcw_place.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_place
// works out target cell, scroll count and next cursor for one command
// ----------------------------------------------------------------------------
module tmcw_place import tmcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic [1:0]       op,
	input  logic [7:0]       ch,
	input  logic [6:0]       col,
	input  logic [4:0]       row,
	input  logic             use_position,
	input  logic [COL_W-1:0] cur_col,
	input  logic [ROW_W-1:0] cur_row,
	output place_t           place
);

	logic [COL_W-1:0] c_sel, c_eff;
	logic [ROW_W-1:0] r_sel, r_eff;
	logic [COL_W:0]   c_inc;
	logic             oob, nl, last_row, wrap;

	assign c_sel    = use_position ? COL_W'(col) : cur_col;
	assign r_sel    = use_position ? ROW_W'(row) : cur_row;
	assign oob      = ({1'b0, c_sel} >= (COL_W+1)'(COLUMNS)) || (r_sel >= ROW_W'(ROWS));
	assign c_eff    = oob ? '0 : c_sel;
	assign r_eff    = oob ? ROW_W'(ROWS - 1) : r_sel;
	assign nl       = (ch == NEWLINE_CHAR);
	assign last_row = (r_eff == ROW_W'(ROWS - 1));
	assign c_inc    = {1'b0, c_eff} + 1'b1;
	assign wrap     = (c_inc == (COL_W+1)'(COLUMNS));

	always_comb begin
		place          = '0;
		place.c        = c_eff;
		place.r        = r_eff;
		place.nxt_col  = cur_col;
		place.nxt_row  = cur_row;
		unique case (op)
			OP_PUT: begin
				place.scroll_n = {1'b0, oob} + {1'b0, nl && last_row};
				if (nl) begin
					place.nxt_col = '0;
					place.nxt_row = last_row ? r_eff : r_eff + 1'b1;
				end else begin
					place.wr_cell = 1'b1;
					place.nxt_col = wrap ? '0 : c_inc[COL_W-1:0];
					place.nxt_row = wrap ? r_eff + 1'b1 : r_eff;
				end
			end
			OP_CLEAR: begin
				place.nxt_col = '0;
				place.nxt_row = '0;
			end
			OP_READ: begin
				place.rd_ok = ((COL_W+1)'(col) < (COL_W+1)'(COLUMNS)) &&
					(ROW_W'(row) < ROW_W'(ROWS));
				place.c     = COL_W'(col);
				place.r     = ROW_W'(row);
			end
			default: begin
				// unused op: cursor stays, nothing changes
			end
		endcase
	end

endmodule

/* sv/text_mode_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer
// character/attribute grid with cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
// usage
//  - cmd channel takes one item per command: put (op 0), clear (op 1),
//    read (op 2); rsp channel returns exactly one item per command with the
//    cursor after the command, a scrolled flag and the read cell
//  - cfg_we/cfg_wdata write the attribute byte (reset 0x0F, zero means 0x0F)
//  - cells live in one single-port-write, one-read-port ram of
//    COLUMNS*ROWS words; every multi-cell operation is a sweep over it
//  - put without scroll: the finish state writes the cell and parks the response
//  - read: address (on accept), ram read, then response
//  - each scroll adds a pass that copies each row up a cell per cycle,
//    zeroes the last row and drains; a put can scroll twice
//  - clear: a fill sweep with one fill write per cycle, then the response
//  - after reset a zeroing pass over all COLUMNS*ROWS cells runs with cmd.ready
//    low; attribute writes are taken during it
//  - one command is worked on at a time; cmd.ready is high again as soon as
//    the response is parked in the output register, so a stalled receiver
//    holds at most one waiting response plus one command in flight
// ----------------------------------------------------------------------------
module text_mode_console_writer import tmcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tmcw_cmd_if.sink   cmd,
	tmcw_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_SCROLL = 6'b000100,
		S_FILL   = 6'b001000,
		S_RD     = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       scroll_left_q;
	place_t           pl_q;
	place_t           place;
	logic [7:0]       ch_q;
	logic [7:0]       attr_q;
	logic [7:0]       eff_attr;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;

	// scroll copy pipeline: read issued in s0, written back in s1
	logic             cp_v_s1;
	logic             cp_copy_s1;
	logic [AW-1:0]    cp_addr_s1;

	// output register
	logic             out_v_q;
	logic [6:0]       out_col_q;
	logic [4:0]       out_row_q;
	logic             out_scr_q;
	logic [7:0]       out_char_q;
	logic [7:0]       out_attr_q;
	logic             out_free;

	// cell ram
	logic [15:0]      mem [CELLS];
	logic [15:0]      rd_data_q;
	logic             we, rd_en;
	logic [AW-1:0]    wa, ra, cell_addr;
	logic [15:0]      wd;
	logic             accept, copy_phase;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == S_IDLE);
	assign out_free   = !out_v_q || rsp.ready;
	assign eff_attr   = (attr_q == 8'd0) ? DEFAULT_ATTR : attr_q;
	assign cell_addr  = AW'(pl_q.r) * AW'(COLUMNS) + AW'(pl_q.c);
	assign copy_phase = (cnt_q < CNT_W'(CELLS - COLUMNS));

	tmcw_place #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_place (
		.op           (cmd.op),
		.ch           (cmd.ch),
		.col          (cmd.col),
		.row          (cmd.row),
		.use_position (cmd.use_position),
		.cur_col      (cur_col_q),
		.cur_row      (cur_row_q),
		.place        (place)
	);

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= DEFAULT_ATTR;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	// ram write port: scroll write-back, then init zeroing and fill sweeps, then the put write
	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = '0;
		priority if (cp_v_s1) begin
			we = 1'b1;
			wa = cp_addr_s1;
			wd = cp_copy_s1 ? rd_data_q : '0;
		end else if (state_q == S_INIT) begin
			we = 1'b1;
		end else if (state_q == S_FILL) begin
			we = 1'b1;
			wd = {eff_attr, SPACE_CHAR};
		end else if (state_q == S_FIN && out_free && pl_q.wr_cell) begin
			we = 1'b1;
			wa = cell_addr;
			wd = {eff_attr, ch_q};
		end else begin
			we = 1'b0;
		end
	end

	// ram read port: source row during scroll, or the addressed cell
	always_comb begin
		rd_en = 1'b0;
		ra    = cell_addr;
		if (state_q == S_SCROLL && copy_phase) begin
			rd_en = 1'b1;
			ra    = cnt_q[AW-1:0] + AW'(COLUMNS);
		end else if (state_q == S_RD) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_v_s1    <= 1'b0;
			cp_copy_s1 <= 1'b0;
			cp_addr_s1 <= '0;
		end else begin
			cp_v_s1    <= (state_q == S_SCROLL) && (cnt_q < CNT_W'(CELLS));
			cp_copy_s1 <= copy_phase;
			cp_addr_s1 <= cnt_q[AW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			cnt_q         <= '0;
			scroll_left_q <= '0;
			pl_q          <= '0;
			ch_q          <= '0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						pl_q          <= place;
						ch_q          <= cmd.ch;
						scroll_left_q <= place.scroll_n;
						cnt_q         <= '0;
						priority if (cmd.op == OP_CLEAR) begin
							state_q <= S_FILL;
						end else if (place.scroll_n != 2'd0) begin
							state_q <= S_SCROLL;
						end else if (place.rd_ok) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCROLL: begin
					if (cnt_q == CNT_W'(CELLS)) begin
						// drain cycle done, start the next pass or finish
						cnt_q         <= '0;
						scroll_left_q <= scroll_left_q - 1'b1;
						if (scroll_left_q == 2'd1) begin
							state_q <= S_FIN;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						cur_col_q <= pl_q.nxt_col;
						cur_row_q <= pl_q.nxt_row;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_col_q  <= pl_q.nxt_col[6:0];
			out_row_q  <= pl_q.nxt_row[4:0];
			out_scr_q  <= (pl_q.scroll_n != 2'd0);
			out_char_q <= pl_q.rd_ok ? rd_data_q[7:0] : 8'd0;
			out_attr_q <= pl_q.rd_ok ? rd_data_q[15:8] : 8'd0;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.scrolled   = out_scr_q;
	assign rsp.cell_char  = out_char_q;
	assign rsp.cell_attr  = out_attr_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for text_mode_console_writer: a queue-fed command
// driver and a response monitor with random gaps, checked against a
// cycle-free model of the 80x25 console grid, cursor and attribute register
// ----------------------------------------------------------------------------
module tb_top;
	import tmcw_pkg::*;

	localparam int GRID_COLS  = COLUMNS_DEF;
	localparam int GRID_ROWS  = ROWS_DEF;
	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int CLK_HALF   = 4;
	// nothing accepted for this long means the block is stuck; the slowest
	// legit wait is a double scroll behind a long stall
	localparam int STUCK_LIMIT = 20000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [6:0] col;
		logic [4:0] row;
		logic       use_position;
	} console_cmd_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
	} console_rsp_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [7:0]   cfg_wdata = 8'h00;
	logic         cmd_valid = 1'b0;
	console_cmd_t cmd_bus   = '0;
	logic         rsp_ready = 1'b0;

	tmcw_cmd_if cmd_if ();
	tmcw_rsp_if rsp_if ();

	assign cmd_if.valid        = cmd_valid;
	assign cmd_if.op           = cmd_bus.op;
	assign cmd_if.ch           = cmd_bus.ch;
	assign cmd_if.col          = cmd_bus.col;
	assign cmd_if.row          = cmd_bus.row;
	assign cmd_if.use_position = cmd_bus.use_position;
	assign rsp_if.ready        = rsp_ready;

	text_mode_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// console model: grid, cursor and attribute copy
	// ------------------------------------------------------------------
	logic [15:0]  shadow_grid [GRID_CELLS];
	int unsigned  shadow_cursor;
	logic [7:0]   shadow_attr;

	console_cmd_t cmd_backlog [$];   // items waiting to be driven
	console_rsp_t replies_due [$];   // predicted responses, oldest first
	int           fault_count = 0;
	int           calm_left [2] = '{0, 0};

	// move every row up by one, blank the bottom row
	function automatic void shift_rows_up();
		for (int i = 0; i < GRID_CELLS - GRID_COLS; i++)
			shadow_grid[i] = shadow_grid[i + GRID_COLS];
		for (int i = GRID_CELLS - GRID_COLS; i < GRID_CELLS; i++)
			shadow_grid[i] = 16'h0000;
	endfunction

	function automatic console_rsp_t console_step(console_cmd_t c);
		console_rsp_t r;
		int unsigned  pc;
		int unsigned  pr;
		int unsigned  idx;
		logic [7:0]   a;
		r = '0;
		a = (shadow_attr == 8'h00) ? DEFAULT_ATTR : shadow_attr;
		case (c.op)
			OP_PUT: begin
				if (c.use_position) begin
					pc = c.col;
					pr = c.row;
				end else begin
					pc = shadow_cursor % GRID_COLS;
					pr = shadow_cursor / GRID_COLS;
				end
				// off the grid (given position or cursor past the end):
				// scroll first and land at the start of the bottom row
				if (pc >= GRID_COLS || pr >= GRID_ROWS) begin
					shift_rows_up();
					r.scrolled = 1'b1;
					pc = 0;
					pr = GRID_ROWS - 1;
				end
				if (c.ch == NEWLINE_CHAR) begin
					if (pr == GRID_ROWS - 1) begin
						shift_rows_up();
						r.scrolled = 1'b1;
						shadow_cursor = (GRID_ROWS - 1) * GRID_COLS;
					end else begin
						shadow_cursor = (pr + 1) * GRID_COLS;
					end
				end else begin
					idx = pr * GRID_COLS + pc;
					shadow_grid[idx] = {a, c.ch};
					shadow_cursor = idx + 1;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < GRID_CELLS; i++)
					shadow_grid[i] = {a, SPACE_CHAR};
				shadow_cursor = 0;
			end
			OP_READ: begin
				if (c.col < GRID_COLS && c.row < GRID_ROWS)
					{r.cell_attr, r.cell_char} = shadow_grid[c.row * GRID_COLS + c.col];
			end
			default: ;
		endcase
		r.cursor_col = 7'(shadow_cursor % GRID_COLS);
		r.cursor_row = 5'(shadow_cursor / GRID_COLS);
		return r;
	endfunction

	// gap length: mostly none or short, a few long, and now and then a calm
	// stretch of back-to-back items; side 0 is the sender, 1 the receiver
	function automatic int pick_pause(int side);
		int roll;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm_left[side] = $urandom_range(20, 40);
			return 0;
		end
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// ------------------------------------------------------------------
	// command driver
	// ------------------------------------------------------------------
	int send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_bus   <= '0;
			send_gap  = 0;
		end else begin
			// item taken: predict its response right now
			if (cmd_valid && cmd_if.ready) begin
				replies_due.push_back(console_step(cmd_bus));
				send_gap = pick_pause(0);
			end
			// bus is free for the next item
			if (!cmd_valid || cmd_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd_bus   <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// response monitor and checker
	// ------------------------------------------------------------------
	int           stall_left = 0;
	console_rsp_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_if.valid && rsp_ready) begin
				if (replies_due.size() == 0) begin
					$error("response item with none outstanding");
					fault_count++;
				end else begin
					want = replies_due.pop_front();
					if (rsp_if.cursor_col !== want.cursor_col) begin
						$error("cursor_col: expected %0d, actual %0d",
							want.cursor_col, rsp_if.cursor_col);
						fault_count++;
					end
					if (rsp_if.cursor_row !== want.cursor_row) begin
						$error("cursor_row: expected %0d, actual %0d",
							want.cursor_row, rsp_if.cursor_row);
						fault_count++;
					end
					if (rsp_if.scrolled !== want.scrolled) begin
						$error("scrolled: expected %0d, actual %0d",
							want.scrolled, rsp_if.scrolled);
						fault_count++;
					end
					if (rsp_if.cell_char !== want.cell_char) begin
						$error("cell_char: expected 0x%02h, actual 0x%02h",
							want.cell_char, rsp_if.cell_char);
						fault_count++;
					end
					if (rsp_if.cell_attr !== want.cell_attr) begin
						$error("cell_attr: expected 0x%02h, actual 0x%02h",
							want.cell_attr, rsp_if.cell_attr);
						fault_count++;
					end
				end
				stall_left = pick_pause(1);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles in a row with no item moving on either side
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_if.ready) || (rsp_if.valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	logic [6:0] last_col = 7'd0;
	logic [4:0] last_row = 5'd0;

	function automatic void queue_cmd(logic [1:0] op, logic [7:0] ch, logic [6:0] col,
		logic [4:0] row, logic use_position);
		console_cmd_t c;
		c.op           = op;
		c.ch           = ch;
		c.col          = col;
		c.row          = row;
		c.use_position = use_position;
		cmd_backlog.push_back(c);
	endfunction

	// every field random, so unused bits still toggle
	function automatic console_cmd_t any_cmd();
		console_cmd_t c;
		c.op           = 2'($urandom_range(0, 3));
		c.ch           = 8'($urandom_range(0, 255));
		c.col          = 7'($urandom_range(0, 127));
		c.row          = 5'($urandom_range(0, 31));
		c.use_position = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// wait until every item is sent and every response is back, then let
	// the block settle so it is surely idle
	task automatic wait_drained();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || cmd_valid || replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attr(logic [7:0] value);
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		shadow_attr = value;
		@(posedge clk);
		cfg_we      <= 1'b0;
	endtask

	task automatic run_random(int count);
		int           made;
		int           pick;
		int           run_len;
		console_cmd_t c;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			c = any_cmd();
			c.op = OP_PUT;
			c.use_position = 1'b0;
			if (pick < 2) begin
				c.op = OP_CLEAR;
			end else if (pick < 5) begin
				// position off the grid: scroll, then write or newline
				c.use_position = 1'b1;
				if ($urandom_range(0, 1))
					c.col = 7'($urandom_range(GRID_COLS, 127));
				else
					c.row = 5'($urandom_range(GRID_ROWS, 31));
				if ($urandom_range(0, 3) == 0)
					c.ch = NEWLINE_CHAR;
			end else if (pick < 8) begin
				// jump near the end of a line and keep typing across it;
				// on the bottom row this runs the cursor past the end
				c.use_position = 1'b1;
				c.col = 7'($urandom_range(GRID_COLS - 4, GRID_COLS - 1));
				c.row = $urandom_range(0, 1) ? 5'(GRID_ROWS - 1)
					: 5'($urandom_range(0, GRID_ROWS - 1));
				c.ch = 8'($urandom_range(32, 126));
				last_col = c.col;
				last_row = c.row;
				cmd_backlog.push_back(c);
				made++;
				run_len = $urandom_range(2, 6);
				for (int k = 0; k < run_len; k++) begin
					c = any_cmd();
					c.op = OP_PUT;
					c.use_position = 1'b0;
					if ($urandom_range(0, 5) == 0)
						c.ch = NEWLINE_CHAR;
					cmd_backlog.push_back(c);
					made++;
				end
				c = any_cmd();
				c.op = OP_READ;
				c.col = last_col;
				c.row = last_row;
			end else if (pick < 18) begin
				c.op = OP_READ;
				if ($urandom_range(0, 1)) begin
					c.col = last_col;
					c.row = last_row;
				end else begin
					c.col = 7'($urandom_range(0, GRID_COLS - 1));
					c.row = 5'($urandom_range(0, GRID_ROWS - 1));
				end
			end else if (pick < 21) begin
				// read outside the grid returns zeros
				c.op = OP_READ;
				if ($urandom_range(0, 1))
					c.col = 7'($urandom_range(GRID_COLS, 127));
				else
					c.row = 5'($urandom_range(GRID_ROWS, 31));
			end else if (pick == 21) begin
				// unused op: the block leaves grid and cursor as they are, so not counted
				c.op = OP_UNUSED;
				made--;
			end else if (pick < 30) begin
				c.ch = NEWLINE_CHAR;
			end else if (pick < 40) begin
				c.use_position = 1'b1;
				c.col = 7'($urandom_range(0, GRID_COLS - 1));
				c.row = 5'($urandom_range(0, GRID_ROWS - 1));
				last_col = c.col;
				last_row = c.row;
			end
			cmd_backlog.push_back(c);
			made++;
		end
	endtask

	initial begin
		for (int i = 0; i < GRID_CELLS; i++)
			shadow_grid[i] = 16'h0000;
		shadow_cursor = 0;
		shadow_attr   = DEFAULT_ATTR;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part with the attribute still at its reset value
		queue_cmd(OP_READ, 8'h00, 7'd0, 5'd0, 1'b0);              // untouched cell
		queue_cmd(OP_PUT, 8'h41, 7'd0, 5'd0, 1'b0);               // put at cursor
		queue_cmd(OP_READ, 8'hFF, 7'd0, 5'd0, 1'b1);
		queue_cmd(OP_PUT, 8'hFF, 7'd79, 5'd0, 1'b1);              // last column wraps
		queue_cmd(OP_PUT, 8'h00, 7'd127, 5'd31, 1'b0);            // char zero at cursor
		queue_cmd(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd0, 1'b0);        // plain newline
		queue_cmd(OP_PUT, 8'h78, 7'd127, 5'd31, 1'b1);            // off grid: scroll
		queue_cmd(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd24, 1'b1);       // newline on bottom row
		queue_cmd(OP_PUT, 8'h5A, 7'd79, 5'd24, 1'b1);             // cursor goes past end
		queue_cmd(OP_READ, 8'h00, 7'd79, 5'd24, 1'b0);
		queue_cmd(OP_PUT, 8'h71, 7'd0, 5'd0, 1'b0);               // past end: scroll
		queue_cmd(OP_PUT, 8'h7A, 7'd79, 5'd24, 1'b1);
		queue_cmd(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd0, 1'b0);        // double scroll
		queue_cmd(OP_READ, 8'h00, 7'd80, 5'd0, 1'b0);             // read off grid
		queue_cmd(OP_READ, 8'h00, 7'd0, 5'd25, 1'b0);
		queue_cmd(OP_READ, 8'hFF, 7'd127, 5'd31, 1'b1);
		queue_cmd(OP_UNUSED, 8'hFF, 7'd127, 5'd31, 1'b1);
		queue_cmd(OP_CLEAR, 8'h00, 7'd0, 5'd0, 1'b0);
		queue_cmd(OP_READ, 8'h00, 7'd79, 5'd24, 1'b0);            // cleared cell
		queue_cmd(OP_PUT, 8'h7E, 7'd0, 5'd0, 1'b0);
		queue_cmd(OP_READ, 8'h00, 7'd0, 5'd0, 1'b0);
		queue_cmd(OP_PUT, NEWLINE_CHAR, 7'd80, 5'd0, 1'b1);       // off grid then newline
		queue_cmd(OP_READ, 8'h00, 7'd0, 5'd23, 1'b0);
		// drained here: the stimulus waits until every response has come
		wait_drained();

		// random phases, each under its own attribute setting
		write_attr(8'h00);
		run_random(250);
		wait_drained();
		write_attr(8'hFF);
		run_random(250);
		wait_drained();
		write_attr(8'h01);
		run_random(250);
		wait_drained();
		write_attr(8'($urandom_range(2, 254)));
		run_random(250);
		wait_drained();

		repeat (20) @(posedge clk);
		if (fault_count == 0 && replies_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
